[hw/rtl/tevq_pkg.sv]
// Shared types and constants for the timed event queue.
// Used by tevq_ctrl, tevq_dp and timed_event_queue; no dependencies.
package tevq_pkg;

  // Default sizes, fixed field widths and the per-tick fire limit
  localparam int NumSlotsDef = 16;
  localparam int TimeBitsDef = 48;
  localparam int IdW         = 48;
  localparam int PeriodW     = 32;
  localparam int MaxFire     = 16;
  localparam int CntW        = $clog2(MaxFire + 1);

  // Command codes of an input beat
  typedef enum logic [1:0] {
    CMD_REG   = 2'd0,
    CMD_UNREG = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  // Status codes of a result beat
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_FIRED     = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_REG_SCAN,
    S_REG_DONE,
    S_UNREG_SCAN,
    S_UNREG_DONE,
    S_TICK_SCAN,
    S_TICK_DECIDE,
    S_TICK_FIRE,
    S_RSVD
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    scan_first;
    logic    reg_commit;
    logic    tick_fire;
    logic    emit;
    status_e emit_status;
    logic    emit_last;
    logic    emit_pend;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic free_found;
    logic hit;
    logic best_vld;
    logic pend_vld;
    logic more_ok;
    logic out_free;
  } dp_sts_t;

endpackage

[hw/rtl/tevq_ctrl.sv]
// Controller state machine of the timed event queue.
// Depends on tevq_pkg; drives dp_cmd_t into tevq_dp and reads dp_sts_t back.
module tevq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  tevq_pkg::dp_sts_t sts_i,
  output tevq_pkg::dp_cmd_t cmd_o
);

  tevq_pkg::state_e state_q, state_d;
  tevq_pkg::cmd_e   in_cmd;
  logic             accept;

  assign in_cmd     = tevq_pkg::cmd_e'(cmd_i);
  assign in_stall_o = (state_q != tevq_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tevq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tevq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            tevq_pkg::CMD_REG:   state_d = tevq_pkg::S_REG_SCAN;
            tevq_pkg::CMD_UNREG: state_d = tevq_pkg::S_UNREG_SCAN;
            tevq_pkg::CMD_TICK:  state_d = tevq_pkg::S_TICK_SCAN;
            default:             state_d = tevq_pkg::S_RSVD;
          endcase
        end
      end
      tevq_pkg::S_REG_SCAN: begin
        if (sts_i.scan_done) state_d = tevq_pkg::S_REG_DONE;
      end
      tevq_pkg::S_REG_DONE: begin
        if (sts_i.out_free) state_d = tevq_pkg::S_IDLE;
      end
      tevq_pkg::S_UNREG_SCAN: begin
        if (sts_i.scan_done) state_d = tevq_pkg::S_UNREG_DONE;
      end
      tevq_pkg::S_UNREG_DONE: begin
        if (sts_i.out_free) state_d = tevq_pkg::S_IDLE;
      end
      tevq_pkg::S_TICK_SCAN: begin
        if (sts_i.scan_done) state_d = tevq_pkg::S_TICK_DECIDE;
      end
      tevq_pkg::S_TICK_DECIDE: begin
        if (!((sts_i.pend_vld || !sts_i.best_vld) && !sts_i.out_free)) begin
          if (sts_i.best_vld && sts_i.more_ok) state_d = tevq_pkg::S_TICK_FIRE;
          else                                 state_d = tevq_pkg::S_IDLE;
        end
      end
      tevq_pkg::S_TICK_FIRE: begin
        state_d = tevq_pkg::S_TICK_SCAN;
      end
      tevq_pkg::S_RSVD: begin
        if (sts_i.out_free) state_d = tevq_pkg::S_IDLE;
      end
      default: state_d = tevq_pkg::S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = tevq_pkg::ST_OK;
    unique case (state_q)
      tevq_pkg::S_IDLE: begin
        if (accept) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = (in_cmd != tevq_pkg::CMD_RSVD);
          cmd_o.scan_first = (in_cmd == tevq_pkg::CMD_TICK);
        end
      end
      tevq_pkg::S_REG_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.reg_commit  = sts_i.free_found;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = sts_i.free_found ? tevq_pkg::ST_OK : tevq_pkg::ST_FULL;
          cmd_o.emit_last   = 1'b1;
        end
      end
      tevq_pkg::S_UNREG_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = sts_i.hit ? tevq_pkg::ST_OK : tevq_pkg::ST_NOT_FOUND;
          cmd_o.emit_last   = 1'b1;
        end
      end
      tevq_pkg::S_TICK_DECIDE: begin
        // Release the pending fired beat once it is known whether another follows, or an OK beat when nothing fired
        if ((sts_i.pend_vld || !sts_i.best_vld) && sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = sts_i.pend_vld ? tevq_pkg::ST_FIRED : tevq_pkg::ST_OK;
          cmd_o.emit_pend   = sts_i.pend_vld;
          cmd_o.emit_last   = !(sts_i.best_vld && sts_i.more_ok);
        end
      end
      tevq_pkg::S_TICK_FIRE: begin
        cmd_o.tick_fire  = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      tevq_pkg::S_RSVD: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/tevq_dp.sv]
// Datapath of the timed event queue: slot memory, valid and due bits, scan
// counter, earliest-entry tracker and output register. Depends on tevq_pkg.
module tevq_dp #(
  parameter int NUM_SLOTS = tevq_pkg::NumSlotsDef,
  parameter int TIME_BITS = tevq_pkg::TimeBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   cmd_i,
  input  logic [tevq_pkg::IdW-1:0]     trigger_time_i,
  input  logic                         repeat_on_i,
  input  logic [tevq_pkg::PeriodW-1:0] period_i,
  input  logic [tevq_pkg::IdW-1:0]     target_id_i,
  input  logic [tevq_pkg::IdW-1:0]     now_time_i,
  input  tevq_pkg::dp_cmd_t            cmd_in_i,
  output tevq_pkg::dp_sts_t            sts_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [tevq_pkg::IdW-1:0]     fired_id_o,
  output logic                         last_o
);

  localparam int IdxW = $clog2(NUM_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  typedef logic [TIME_BITS-1:0] time_t;

  // Slot memory
  time_t                        mem_trig [NUM_SLOTS];
  logic [tevq_pkg::PeriodW-1:0] mem_per  [NUM_SLOTS];
  logic                         mem_rep  [NUM_SLOTS];

  // Latched input beat
  tevq_pkg::cmd_e               cmd_q;
  time_t                        trig_q, target_q, now_q;
  logic                         rep_q;
  logic [tevq_pkg::PeriodW-1:0] per_q;

  // Scan and read pipeline
  logic [IdxW-1:0]              addr_q, rd_idx_q;
  logic                         issuing_q, rd_vld_q, first_q;
  time_t                        rd_trig_q;
  logic [tevq_pkg::PeriodW-1:0] rd_per_q;
  logic                         rd_rep_q;

  // Per-slot flags
  logic [NUM_SLOTS-1:0]         valid_q, due_q;

  // Scan results
  logic                         free_found_q, hit_q, best_vld_q;
  logic [IdxW-1:0]              free_idx_q, best_idx_q;
  time_t                        best_trig_q;
  logic [tevq_pkg::PeriodW-1:0] best_per_q;
  logic                         best_rep_q;

  // Pending fired beat
  logic                         pend_vld_q;
  time_t                        pend_trig_q;
  logic [tevq_pkg::CntW-1:0]    cnt_q;

  // Output register
  logic                         out_valid_q;
  tevq_pkg::status_e            out_status_q;
  logic [tevq_pkg::IdW-1:0]     out_fired_q;
  logic                         out_last_q;

  logic  slot_v, due_now, is_free, is_hit, is_cand, better, out_free;
  time_t adv_trig;

  // Evaluate the slot read back this cycle
  assign slot_v   = valid_q[rd_idx_q];
  assign due_now  = slot_v && (rd_trig_q <= now_q);
  assign is_free  = rd_vld_q && (cmd_q == tevq_pkg::CMD_REG) && !slot_v;
  assign is_hit   = rd_vld_q && (cmd_q == tevq_pkg::CMD_UNREG) && slot_v &&
                    (rd_trig_q == target_q);
  assign is_cand  = rd_vld_q && (cmd_q == tevq_pkg::CMD_TICK) &&
                    (first_q ? due_now : due_q[rd_idx_q]);
  assign better   = is_cand && (!best_vld_q || (rd_trig_q < best_trig_q));
  assign adv_trig = best_trig_q + TIME_BITS'(best_per_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Report status
  always_comb begin
    sts_o.scan_done  = rd_vld_q && (rd_idx_q == LastIdx);
    sts_o.free_found = free_found_q;
    sts_o.hit        = hit_q;
    sts_o.best_vld   = best_vld_q;
    sts_o.pend_vld   = pend_vld_q;
    sts_o.more_ok    = (cnt_q < tevq_pkg::CntW'(tevq_pkg::MaxFire));
    sts_o.out_free   = out_free;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issuing_q    <= 1'b0;
      rd_vld_q     <= 1'b0;
      first_q      <= 1'b0;
      valid_q      <= '0;
      due_q        <= '0;
      free_found_q <= 1'b0;
      hit_q        <= 1'b0;
      best_vld_q   <= 1'b0;
      pend_vld_q   <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // Clear per-beat state on accept
      if (cmd_in_i.load) begin
        pend_vld_q <= 1'b0;
        cnt_q      <= '0;
      end
      // Advance the scan address
      if (cmd_in_i.scan_start) begin
        addr_q       <= '0;
        issuing_q    <= 1'b1;
        first_q      <= cmd_in_i.scan_first;
        free_found_q <= 1'b0;
        hit_q        <= 1'b0;
        best_vld_q   <= 1'b0;
      end else if (issuing_q) begin
        addr_q <= addr_q + IdxW'(1);
        if (addr_q == LastIdx) issuing_q <= 1'b0;
      end
      rd_vld_q <= issuing_q;
      // Record scan results
      if (is_free && !free_found_q) free_found_q <= 1'b1;
      if (is_hit) begin
        hit_q             <= 1'b1;
        valid_q[rd_idx_q] <= 1'b0;
      end
      if (rd_vld_q && (cmd_q == tevq_pkg::CMD_TICK) && first_q) due_q[rd_idx_q] <= due_now;
      if (better) best_vld_q <= 1'b1;
      // Commit a registration
      if (cmd_in_i.reg_commit) valid_q[free_idx_q] <= 1'b1;
      // Fire the earliest due entry
      if (cmd_in_i.tick_fire) begin
        due_q[best_idx_q] <= 1'b0;
        if (!best_rep_q) valid_q[best_idx_q] <= 1'b0;
        pend_vld_q <= 1'b1;
        cnt_q      <= cnt_q + tevq_pkg::CntW'(1);
      end
      // Hold or drop the output beat
      if (cmd_in_i.emit)     out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers and slot memory
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load) begin
      cmd_q    <= tevq_pkg::cmd_e'(cmd_i);
      trig_q   <= TIME_BITS'(trigger_time_i);
      rep_q    <= repeat_on_i;
      per_q    <= period_i;
      target_q <= TIME_BITS'(target_id_i);
      now_q    <= TIME_BITS'(now_time_i);
    end
    rd_idx_q <= addr_q;
    if (issuing_q) begin
      rd_trig_q <= mem_trig[addr_q];
      rd_per_q  <= mem_per[addr_q];
      rd_rep_q  <= mem_rep[addr_q];
    end
    if (cmd_in_i.reg_commit) begin
      mem_trig[free_idx_q] <= trig_q;
      mem_per[free_idx_q]  <= per_q;
      mem_rep[free_idx_q]  <= rep_q;
    end else if (cmd_in_i.tick_fire && best_rep_q) begin
      mem_trig[best_idx_q] <= adv_trig;
    end
    if (is_free && !free_found_q) free_idx_q <= rd_idx_q;
    if (better) begin
      best_idx_q  <= rd_idx_q;
      best_trig_q <= rd_trig_q;
      best_per_q  <= rd_per_q;
      best_rep_q  <= rd_rep_q;
    end
    if (cmd_in_i.tick_fire) pend_trig_q <= best_trig_q;
    if (cmd_in_i.emit) begin
      out_status_q <= cmd_in_i.emit_status;
      out_fired_q  <= cmd_in_i.emit_pend ? tevq_pkg::IdW'(pend_trig_q) : '0;
      out_last_q   <= cmd_in_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign fired_id_o  = out_fired_q;
  assign last_o      = out_last_q;

endmodule

[hw/rtl/timed_event_queue.sv]
// Timed event queue: a table of NUM_SLOTS timed tasks keyed by trigger time. A register
// command and an unregister each make one full pass over the slot memory through its single
// read port. A tick makes a first pass and one more pass for each entry it fires, since every
// fired entry needs a fresh pass to find the next earliest one; at most 16 entries fire per tick.
// Fired beats leave earliest first with ties to the lower slot; the output register lets a
// new command be accepted while the final result beat still waits.
// Top level; depends on tevq_pkg, tevq_ctrl and tevq_dp.
module timed_event_queue #(
  parameter int NUM_SLOTS = tevq_pkg::NumSlotsDef,
  parameter int TIME_BITS = tevq_pkg::TimeBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   cmd_i,
  input  logic [tevq_pkg::IdW-1:0]     trigger_time_i,
  input  logic                         repeat_on_i,
  input  logic [tevq_pkg::PeriodW-1:0] period_i,
  input  logic [tevq_pkg::IdW-1:0]     target_id_i,
  input  logic [tevq_pkg::IdW-1:0]     now_time_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [tevq_pkg::IdW-1:0]     fired_id_o,
  output logic                         last_o
);

  tevq_pkg::dp_cmd_t dp_cmd;
  tevq_pkg::dp_sts_t dp_sts;

  // Sequence commands
  tevq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Hold slots and results
  tevq_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .trigger_time_i (trigger_time_i),
    .repeat_on_i    (repeat_on_i),
    .period_i       (period_i),
    .target_id_i    (target_id_i),
    .now_time_i     (now_time_i),
    .cmd_in_i       (dp_cmd),
    .sts_o          (dp_sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .fired_id_o     (fired_id_o),
    .last_o         (last_o)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for timed_event_queue: directed and random command beats,
// each result beat checked against an in-bench prediction of the slot table.
// Depends on tevq_pkg and the timed_event_queue RTL.
module tb_top;
  import tevq_pkg::*;

  localparam int Slots = NumSlotsDef;
  localparam int WatchLimit = 4000;
  localparam int DrainCycles = 4 * (NumSlotsDef + 4);
  localparam logic [IdW-1:0] TimeMax = '1;

  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   id;
    logic             last;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         cmd_i = CMD_REG;
  logic [IdW-1:0]     trigger_time_i = '0;
  logic               repeat_on_i = 1'b0;
  logic [PeriodW-1:0] period_i = '0;
  logic [IdW-1:0]     target_id_i = '0;
  logic [IdW-1:0]     now_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [IdW-1:0]     fired_id_o;
  logic               last_o;

  // Predicted slot table
  bit                 tbl_valid [Slots];
  logic [IdW-1:0]     tbl_trigger [Slots];
  logic [PeriodW-1:0] tbl_period [Slots];
  logic               tbl_repeat [Slots];

  result_t            expected_beats [$];
  int                 errors = 0;
  bit                 idle_en = 1'b1;
  logic [IdW-1:0]     clock_ms = 48'd1000;

  timed_event_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .trigger_time_i (trigger_time_i),
    .repeat_on_i    (repeat_on_i),
    .period_i       (period_i),
    .target_id_i    (target_id_i),
    .now_time_i     (now_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .fired_id_o     (fired_id_o),
    .last_o         (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [IdW-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Update the predicted table for one accepted command and queue its result beats
  function automatic void predict_command(logic [1:0] cmd, logic [IdW-1:0] trig, logic rep,
                                          logic [PeriodW-1:0] per, logic [IdW-1:0] tid,
                                          logic [IdW-1:0] now);
    bit      done;
    bit      due [Slots];
    int      pick;
    int      fired;
    result_t r;
    r.status = ST_OK;
    r.id = '0;
    r.last = 1'b1;
    case (cmd)
      CMD_REG: begin
        done = 1'b0;
        for (int i = 0; i < Slots; i++) begin
          if (!done && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_trigger[i] = trig;
            tbl_repeat[i] = rep;
            tbl_period[i] = per;
            done = 1'b1;
          end
        end
        if (!done) r.status = ST_FULL;
        expected_beats.push_back(r);
      end
      CMD_UNREG: begin
        done = 1'b0;
        for (int i = 0; i < Slots; i++) begin
          if (tbl_valid[i] && tbl_trigger[i] == tid) begin
            tbl_valid[i] = 1'b0;
            done = 1'b1;
          end
        end
        if (!done) r.status = ST_NOT_FOUND;
        expected_beats.push_back(r);
      end
      CMD_TICK: begin
        // Snapshot what is due on arrival; each entry fires at most once
        for (int i = 0; i < Slots; i++) due[i] = tbl_valid[i] && tbl_trigger[i] <= now;
        fired = 0;
        while (fired < MaxFire) begin
          pick = -1;
          for (int i = 0; i < Slots; i++) begin
            if (due[i] && (pick < 0 || tbl_trigger[i] < tbl_trigger[pick])) pick = i;
          end
          if (pick < 0) break;
          due[pick] = 1'b0;
          r.status = ST_FIRED;
          r.id = tbl_trigger[pick];
          r.last = 1'b0;
          expected_beats.push_back(r);
          fired++;
          if (tbl_repeat[pick]) tbl_trigger[pick] = tbl_trigger[pick] + IdW'(tbl_period[pick]);
          else tbl_valid[pick] = 1'b0;
        end
        if (fired == 0) begin
          r.status = ST_OK;
          r.id = '0;
          r.last = 1'b1;
          expected_beats.push_back(r);
        end else begin
          r = expected_beats.pop_back();
          r.last = 1'b1;
          expected_beats.push_back(r);
        end
      end
      default: begin
        expected_beats.push_back(r);
      end
    endcase
  endfunction

  // Drive one command beat, hold it until accepted, then predict it
  task automatic send_beat(logic [1:0] cmd, logic [IdW-1:0] trig, logic rep,
                           logic [PeriodW-1:0] per, logic [IdW-1:0] tid, logic [IdW-1:0] now);
    int gap;
    if (idle_en && $urandom_range(0, 99) < 16) begin
      gap = $urandom_range(1, 20);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    trigger_time_i <= trig;
    repeat_on_i    <= rep;
    period_i       <= per;
    target_id_i    <= tid;
    now_time_i     <= now;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_command(cmd, trig, rep, per, tid, now);
  endtask

  // Unused fields of each command carry random noise
  task automatic send_register(logic [IdW-1:0] trig, logic rep, logic [PeriodW-1:0] per);
    send_beat(CMD_REG, trig, rep, per, rand48(), rand48());
  endtask

  task automatic send_unregister(logic [IdW-1:0] tid);
    send_beat(CMD_UNREG, rand48(), 1'($urandom), $urandom, tid, rand48());
  endtask

  task automatic send_tick(logic [IdW-1:0] now);
    send_beat(CMD_TICK, rand48(), 1'($urandom), $urandom, rand48(), now);
  endtask

  task automatic send_reserved();
    send_beat(CMD_RSVD, rand48(), 1'($urandom), $urandom, rand48(), rand48());
  endtask

  task automatic test_empty_table();
    send_tick(TimeMax);
    send_tick('0);
    send_unregister(rand48());
    send_reserved();
  endtask

  // Fill every slot, overflow once, then fire all sixteen in one tick
  task automatic test_fill_and_fire();
    send_register('0, 1'b1, '0);
    send_register(TimeMax, 1'b1, '1);
    send_register(48'd5, 1'b0, 32'd7);
    send_register(48'd100, 1'b0, 32'd3);
    send_register(48'd100, 1'b0, 32'd9);
    send_register(48'd100, 1'b1, 32'd1);
    for (int i = 0; i < Slots - 6; i++) send_register(rand48(), 1'(i), $urandom);
    send_register(rand48(), 1'b0, $urandom);
    send_tick(TimeMax);
    send_unregister(48'd101);
    send_unregister('0);
  endtask

  // Mostly well-formed traffic around a running clock, with some noise mixed in
  task automatic run_mixed_traffic(int count);
    int             pick;
    int             live [$];
    logic [IdW-1:0] trig;
    logic [PeriodW-1:0] per;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) trig = clock_ms + $urandom_range(0, 60);
        else if (pick < 90) trig = rand48();
        else trig = ($urandom_range(0, 1) != 0) ? TimeMax : '0;
        pick = $urandom_range(0, 99);
        if (pick < 60) per = $urandom_range(1, 40);
        else if (pick < 75) per = '0;
        else per = $urandom;
        send_register(trig, 1'($urandom), per);
      end else if (pick < 55) begin
        live.delete();
        for (int i = 0; i < Slots; i++) if (tbl_valid[i]) live.push_back(i);
        if (live.size() > 0 && $urandom_range(0, 99) < 65)
          trig = tbl_trigger[live[$urandom_range(0, live.size() - 1)]];
        else if ($urandom_range(0, 1) != 0) trig = rand48();
        else trig = clock_ms + $urandom_range(0, 60);
        send_unregister(trig);
      end else if (pick < 97) begin
        if ($urandom_range(0, 99) < 85) begin
          clock_ms = clock_ms + $urandom_range(0, 25);
          send_tick(clock_ms);
        end else begin
          send_tick(rand48());
        end
      end else begin
        send_reserved();
      end
    end
  endtask

  task automatic test_calm_stretch();
    idle_en = 1'b0;
    run_mixed_traffic(100);
    idle_en = 1'b1;
  endtask

  // Hold off the sender until every queued result has left
  task automatic test_drain_pause();
    run_mixed_traffic(20);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    run_mixed_traffic(20);
  endtask

  task automatic test_random_mix();
    run_mixed_traffic(210);
  endtask

  // Check each accepted result beat and drive random back-pressure
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: status %0d fired_id %h last %0b",
               status_o, fired_id_o, last_o);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          errors++;
        end
        if (fired_id_o !== want.id) begin
          $error("fired_id: expected %h, actual %h", want.id, fired_id_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          errors++;
        end
      end
    end
    out_stall_i <= idle_en && ($urandom_range(0, 99) < 16);
  end

  // End the run when no beat moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_and_fire();
    test_calm_stretch();
    test_drain_pause();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_beats.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
